// File: design/priority_twist_mux_watchdog_macros.svh
// Assertion macros for the priority command multiplexer.
// Taken in by the top level; needs no other file.
`ifndef PRIORITY_TWIST_MUX_WATCHDOG_MACROS_SVH
`define PRIORITY_TWIST_MUX_WATCHDOG_MACROS_SVH

// A condition that must hold at the same edge as its trigger.
`define PTMW_ASSERT_SAME(label, clk, rstn, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |-> (cond)) \
        else $error("ptmw: same-cycle check failed");

// A condition that must hold at the edge after its trigger.
`define PTMW_ASSERT_NEXT(label, clk, rstn, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (cond)) \
        else $error("ptmw: next-cycle check failed");

`endif

// File: design/ptmw_pkg.sv
// Shared types and constants of the priority command multiplexer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package ptmw_pkg;

    // Request types of an input word.
    localparam logic REQ_COMMAND = 1'b0;
    localparam logic REQ_CHECK   = 1'b1;

    // Kinds of a result word.
    localparam logic KIND_FORWARD = 1'b0;
    localparam logic KIND_ZERO    = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_OFF   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_REPS  = 2'd2;

    // Configuration reset values.
    localparam logic [15:0] HOLD_OFF_RESET   = 16'd500;
    localparam logic [15:0] STOP_DELAY_RESET = 16'd100;
    localparam logic [7:0]  ZERO_REPS_RESET  = 8'd5;

    typedef struct packed {
        logic               req_type;
        logic [31:0]        now_ms;
        logic [2:0]         source_priority;
        logic signed [31:0] cmd_linear;
        logic signed [31:0] cmd_angular;
    } item_t;

    typedef struct packed {
        logic               out_kind;
        logic signed [31:0] out_linear;
        logic signed [31:0] out_angular;
    } result_t;

    typedef struct packed {
        logic [15:0] hold_off_ms;
        logic [15:0] stop_delay_ms;
        logic [7:0]  zero_repeats;
    } cfg_t;

    typedef struct packed {
        logic       stop_armed;
        logic [7:0] zeros_sent;
        logic [2:0] held_level;
    } status_t;

endpackage

// File: design/ptmw_in_reg.sv
// Input register slice of the priority command multiplexer.
// Depends on ptmw_pkg for the input word type.
`timescale 1ns / 1ps

module ptmw_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ptmw_pkg::item_t s_item,
    output logic           q_valid,
    input  logic           q_ready,
    output ptmw_pkg::item_t q_item
);
    import ptmw_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // The slot takes a new word when it is empty or is being drained.
    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_item  = item_reg;

    // Valid flag of the slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // Payload of the slot.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// File: design/ptmw_arbiter.sv
// Priority arbitration and stop watchdog state of the multiplexer.
// Depends on ptmw_pkg for word, configuration and status types.
`timescale 1ns / 1ps

module ptmw_arbiter #(
    parameter int NUM_SOURCES = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ptmw_pkg::cfg_t    cfg,
    input  logic             fire,
    input  ptmw_pkg::item_t   item,
    output logic             res_valid,
    output ptmw_pkg::result_t result,
    output ptmw_pkg::status_t status
);
    import ptmw_pkg::*;

    localparam logic [8:0] NUM_SRC_W = 9'(NUM_SOURCES);

    logic [2:0]  held_level_reg,  held_level_next;
    logic [31:0] last_fwd_reg,    last_fwd_next;
    logic [31:0] last_in_reg,     last_in_next;
    logic        stop_armed_reg,  stop_armed_next;
    logic [7:0]  zeros_sent_reg,  zeros_sent_next;

    logic [31:0] since_fwd;
    logic [31:0] since_in;
    logic [7:0]  zeros_inc;
    logic        prio_ok;

    assign since_fwd = item.now_ms - last_fwd_reg;
    assign since_in  = item.now_ms - last_in_reg;
    assign zeros_inc = zeros_sent_reg + 8'd1;
    assign prio_ok   = {6'd0, item.source_priority} < NUM_SRC_W;

    // Decision for the word in the input register and the state it leaves.
    always_comb begin
        held_level_next = held_level_reg;
        last_fwd_next   = last_fwd_reg;
        last_in_next    = last_in_reg;
        stop_armed_next = stop_armed_reg;
        zeros_sent_next = zeros_sent_reg;
        res_valid       = 1'b0;
        result.out_kind    = KIND_FORWARD;
        result.out_linear  = item.cmd_linear;
        result.out_angular = item.cmd_angular;
        if (item.req_type == REQ_COMMAND) begin
            if (prio_ok) begin
                // Forward when not outranked or when the hold-off has run out.
                if (item.source_priority >= held_level_reg
                        || since_fwd > {16'd0, cfg.hold_off_ms}) begin
                    held_level_next = item.source_priority;
                    last_fwd_next   = item.now_ms;
                    res_valid       = 1'b1;
                end
                last_in_next    = item.now_ms;
                stop_armed_next = 1'b1;
            end
        end else begin
            // Watchdog check: send a stop once the input has gone quiet.
            if (stop_armed_reg && since_in > {16'd0, cfg.stop_delay_ms}) begin
                res_valid          = 1'b1;
                result.out_kind    = KIND_ZERO;
                result.out_linear  = 32'sd0;
                result.out_angular = 32'sd0;
                zeros_sent_next    = zeros_inc;
                if (zeros_inc >= cfg.zero_repeats || zeros_inc == 8'd0) begin
                    stop_armed_next = 1'b0;
                    zeros_sent_next = 8'd0;
                end
            end
        end
    end

    // State registers, updated when the word leaves the input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_level_reg <= 3'd0;
            last_fwd_reg   <= 32'd0;
            last_in_reg    <= 32'd0;
            stop_armed_reg <= 1'b0;
            zeros_sent_reg <= 8'd0;
        end else if (fire) begin
            held_level_reg <= held_level_next;
            last_fwd_reg   <= last_fwd_next;
            last_in_reg    <= last_in_next;
            stop_armed_reg <= stop_armed_next;
            zeros_sent_reg <= zeros_sent_next;
        end
    end

    assign status.stop_armed = stop_armed_reg;
    assign status.zeros_sent = zeros_sent_reg;
    assign status.held_level = held_level_reg;

endmodule

// File: design/priority_twist_mux_watchdog.sv
// Top level of the priority command multiplexer with stop watchdog.
// Depends on ptmw_pkg, ptmw_in_reg, ptmw_arbiter and the macros header.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid / s_ready  s_req_type .. s_cmd_angular
//   m_        out        m_valid / m_ready  m_out_kind .. m_out_angular
//   cfg_      in         cfg_wr_en          cfg_wr_index, cfg_wr_data
//
// A word accepted into the input register waits there until the result register is
// free or draining, then passes through the arbitration logic into the result
// register; its result is then offered on the m_ channel.
// One word is accepted every cycle while the result side keeps taking words.
// Reset clears the valid flags and the arbitration state and reloads the
// configuration reset values.
// A stalled result holds the result register, then the input register fills.
`timescale 1ns / 1ps
`include "priority_twist_mux_watchdog_macros.svh"

module priority_twist_mux_watchdog #(
    parameter int NUM_SOURCES = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [ptmw_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [15:0]                        cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_req_type,
    input  logic [31:0]                        s_now_ms,
    input  logic [2:0]                         s_source_priority,
    input  logic signed [31:0]                 s_cmd_linear,
    input  logic signed [31:0]                 s_cmd_angular,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_out_kind,
    output logic signed [31:0]                 m_out_linear,
    output logic signed [31:0]                 m_out_angular
);
    import ptmw_pkg::*;

    cfg_t    cfg_reg;
    item_t   s_item;
    item_t   q_item;
    logic    q_valid;
    logic    q_ready;
    logic    fire;
    logic    res_valid;
    result_t result;
    status_t status;
    logic    m_valid_reg;
    result_t result_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hold_off_ms   <= HOLD_OFF_RESET;
            cfg_reg.stop_delay_ms <= STOP_DELAY_RESET;
            cfg_reg.zero_repeats  <= ZERO_REPS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_HOLD_OFF:   cfg_reg.hold_off_ms   <= cfg_wr_data;
                CFG_STOP_DELAY: cfg_reg.stop_delay_ms <= cfg_wr_data;
                CFG_ZERO_REPS:  cfg_reg.zero_repeats  <= cfg_wr_data[7:0];
                default: ;
            endcase
        end
    end

    // Gather the input word.
    assign s_item.req_type        = s_req_type;
    assign s_item.now_ms          = s_now_ms;
    assign s_item.source_priority = s_source_priority;
    assign s_item.cmd_linear      = s_cmd_linear;
    assign s_item.cmd_angular     = s_cmd_angular;

    ptmw_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    // The held word moves on when the result register is free or draining.
    assign q_ready = !m_valid_reg || m_ready;
    assign fire    = q_valid && q_ready;

    ptmw_arbiter #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_arbiter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .fire      (fire),
        .item      (q_item),
        .res_valid (res_valid),
        .result    (result),
        .status    (status)
    );

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= res_valid;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (fire && res_valid) begin
            result_reg <= result;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_kind    = result_reg.out_kind;
    assign m_out_linear  = result_reg.out_linear;
    assign m_out_angular = result_reg.out_angular;

    // A stop word always carries zero velocities.
    `PTMW_ASSERT_SAME(a_zero_payload, aclk, aresetn, m_valid && m_out_kind == KIND_ZERO, m_out_linear == 32'sd0 && m_out_angular == 32'sd0)
    // A disarmed watchdog has a cleared repeat counter.
    `PTMW_ASSERT_SAME(a_disarmed_clear, aclk, aresetn, !status.stop_armed, status.zeros_sent == 8'd0)
    // The held level is always a valid source index.
    `PTMW_ASSERT_SAME(a_level_range, aclk, aresetn, 1'b1, {6'd0, status.held_level} < 9'(NUM_SOURCES))
    // A stalled result is never overwritten by the word behind it.
    `PTMW_ASSERT_NEXT(a_no_overrun, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(result_reg))

endmodule

// File: test/tb_top.sv
// Self-checking testbench for priority_twist_mux_watchdog: directed and random words,
// checked against an in-bench arbitration and watchdog predictor.
// Depends on ptmw_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
    import ptmw_pkg::*;

    localparam int SOURCES = 8;
    localparam int MAX_REPORTS = 10;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = CFG_HOLD_OFF;
    logic [15:0] cfg_wr_data = 16'd0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_req_type = REQ_COMMAND;
    logic [31:0] s_now_ms = 32'd0;
    logic [2:0] s_source_priority = 3'd0;
    logic signed [31:0] s_cmd_linear = 32'sd0;
    logic signed [31:0] s_cmd_angular = 32'sd0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_out_kind;
    logic signed [31:0] m_out_linear;
    logic signed [31:0] m_out_angular;

    // Words waiting to be offered, and results the block still owes.
    item_t word_queue[$];
    result_t result_q[$];
    int issued_cnt = 0;
    int accepted_cnt = 0;
    int mismatches = 0;
    logic in_fire = 1'b0;

    // Idling controls for both channels.
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    logic sink_hold_start = 1'b0;
    int sink_hold_left = 0;

    // Running timestamp for generated words.
    logic [31:0] stamp_ms = 32'd0;

    // Predictor copy of the configuration and arbitration state.
    logic [15:0] mdl_hold_off;
    logic [15:0] mdl_stop_delay;
    logic [7:0] mdl_zero_reps;
    logic [2:0] mdl_held_level;
    logic [31:0] mdl_last_fwd;
    logic [31:0] mdl_last_cmd;
    logic mdl_armed;
    logic [7:0] mdl_zeros;

    priority_twist_mux_watchdog #(.NUM_SOURCES(SOURCES)) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req_type(s_req_type),
        .s_now_ms(s_now_ms),
        .s_source_priority(s_source_priority),
        .s_cmd_linear(s_cmd_linear),
        .s_cmd_angular(s_cmd_angular),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_out_kind(m_out_kind),
        .m_out_linear(m_out_linear),
        .m_out_angular(m_out_angular)
    );

    // Clock with a 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Arbitrates one accepted word; returns whether it produces a result.
    function automatic logic arbitrate_word(input logic kind, input logic [31:0] now,
                                            input logic [2:0] prio,
                                            input logic signed [31:0] lin,
                                            input logic signed [31:0] ang,
                                            output result_t res);
        logic [31:0] since;
        logic fwd;
        fwd = 1'b0;
        res = '0;
        if (kind == REQ_COMMAND) begin
            // Sources outside the configured range are dropped without trace.
            if (int'(prio) >= SOURCES) return 1'b0;
            since = now - mdl_last_fwd;
            if (prio >= mdl_held_level || since > {16'd0, mdl_hold_off}) begin
                mdl_held_level = prio;
                mdl_last_fwd = now;
                res.out_kind = KIND_FORWARD;
                res.out_linear = lin;
                res.out_angular = ang;
                fwd = 1'b1;
            end
            // Any command re-arms the watchdog, forwarded or not.
            mdl_last_cmd = now;
            mdl_armed = 1'b1;
            return fwd;
        end
        since = now - mdl_last_cmd;
        if (mdl_armed && since > {16'd0, mdl_stop_delay}) begin
            res.out_kind = KIND_ZERO;
            mdl_zeros = mdl_zeros + 8'd1;
            // A repeat count of zero, or one lowered below the count, disarms at once.
            if (mdl_zeros >= mdl_zero_reps || mdl_zeros == 8'd0) begin
                mdl_armed = 1'b0;
                mdl_zeros = 8'd0;
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Tracks configuration writes and accepted words, queuing the results they cause.
    always @(posedge aclk) begin : predict_words
        result_t res;
        if (!aresetn) begin
            mdl_hold_off = HOLD_OFF_RESET;
            mdl_stop_delay = STOP_DELAY_RESET;
            mdl_zero_reps = ZERO_REPS_RESET;
            mdl_held_level = 3'd0;
            mdl_last_fwd = 32'd0;
            mdl_last_cmd = 32'd0;
            mdl_armed = 1'b0;
            mdl_zeros = 8'd0;
            in_fire <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_HOLD_OFF: mdl_hold_off = cfg_wr_data;
                    CFG_STOP_DELAY: mdl_stop_delay = cfg_wr_data;
                    CFG_ZERO_REPS: mdl_zero_reps = cfg_wr_data[7:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (arbitrate_word(s_req_type, s_now_ms, s_source_priority,
                                   s_cmd_linear, s_cmd_angular, res))
                    result_q = {result_q, res};
                accepted_cnt++;
            end
            in_fire <= s_valid && s_ready;
        end
    end

    // Compares each result word with the oldest expectation.
    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result at %0t: kind %0d linear %0d angular %0d",
                             $time, m_out_kind, m_out_linear, m_out_angular);
            end else begin
                want = result_q.pop_front();
                if (m_out_kind !== want.out_kind || m_out_linear !== want.out_linear ||
                    m_out_angular !== want.out_angular) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch at %0t (expected/actual): kind %0d/%0d %s%0d/%0d %s%0d/%0d",
                                 $time, want.out_kind, m_out_kind,
                                 "linear ", want.out_linear, m_out_linear,
                                 "angular ", want.out_angular, m_out_angular);
                end
            end
        end
    end

    // Offers queued words and drives the result side's ready.
    always @(negedge aclk) begin : drive_words
        item_t w;
        if (!s_valid || in_fire) begin
            if (word_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                w = word_queue.pop_front();
                s_req_type <= w.req_type;
                s_now_ms <= w.now_ms;
                s_source_priority <= w.source_priority;
                s_cmd_linear <= w.cmd_linear;
                s_cmd_angular <= w.cmd_angular;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= (sink_hold_left == 0) && ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Counts down a long hold-off on the result side.
    always @(posedge aclk) begin
        if (sink_hold_start) begin
            sink_hold_left <= LONG_HOLD_CYCLES;
        end else if (sink_hold_left != 0) begin
            sink_hold_left <= sink_hold_left - 1;
        end
    end

    task automatic push_word(input logic kind, input logic [31:0] at_ms,
                             input logic [2:0] prio, input logic [31:0] lin,
                             input logic [31:0] ang);
        item_t w;
        w.req_type = kind;
        w.now_ms = at_ms;
        w.source_priority = prio;
        w.cmd_linear = lin;
        w.cmd_angular = ang;
        word_queue = {word_queue, w};
        issued_cnt++;
    endtask

    // Check words carry random payload bits that the block must ignore.
    task automatic push_check(input logic [31:0] at_ms);
        push_word(REQ_CHECK, at_ms, 3'($urandom_range(0, 7)), $urandom, $urandom);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Waits until every word is taken and every result has come, plus pipeline slack.
    task automatic wait_idle();
        do @(negedge aclk);
        while (accepted_cnt != issued_cnt || result_q.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    // Random words, mostly bursts of commands followed by a run of checks.
    task automatic run_words(input int n, input int span, input int zr_lim);
        int sent;
        int k;
        int r;
        logic [31:0] dt;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 99) < 75) begin
                k = $urandom_range(1, 6);
                repeat (k) begin
                    stamp_ms = stamp_ms + $urandom_range(0, span / 3 + 1);
                    push_word(REQ_COMMAND, stamp_ms, 3'($urandom_range(0, 7)),
                              $urandom, $urandom);
                end
                sent += k;
                k = $urandom_range(1, zr_lim);
                repeat (k) begin
                    stamp_ms = stamp_ms + $urandom_range(span / 2, span + 2);
                    push_check(stamp_ms);
                end
                sent += k;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50) dt = $urandom_range(0, span / 8 + 1);
                else if (r < 80) dt = $urandom_range(0, 2 * span + 2);
                else if (r < 90) dt = span - 1 + $urandom_range(0, 2);
                else dt = $urandom;
                stamp_ms = stamp_ms + dt;
                if ($urandom_range(0, 1) == 0)
                    push_word(REQ_COMMAND, stamp_ms, 3'($urandom_range(0, 7)),
                              $urandom, $urandom);
                else
                    push_check(stamp_ms);
                sent++;
            end
        end
    endtask

    // Reconfigures the block once idle, sets the idling mix and queues random words.
    task automatic run_setting(input logic [15:0] hold, input logic [15:0] stop,
                               input logic [7:0] zr, input int src_pct, input int sink_pct,
                               input int n);
        logic [7:0] junk;
        int span;
        int zr_lim;
        junk = 8'($urandom);
        wait_idle();
        write_reg(CFG_HOLD_OFF, hold);
        write_reg(CFG_STOP_DELAY, stop);
        write_reg(CFG_ZERO_REPS, {junk, zr});
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        span = (hold > stop ? int'(hold) : int'(stop)) + 1;
        zr_lim = int'(zr) + 2;
        if (zr_lim > 12) zr_lim = 12;
        run_words(n, span, zr_lim);
    endtask

    // Run limit.
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // Stimulus sequence.
    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words under the reset configuration.
        push_check(32'd50);
        push_word(REQ_COMMAND, 32'd100, 3'd0, 32'h7FFF_FFFF, 32'h8000_0000);
        push_word(REQ_COMMAND, 32'd110, 3'd7, 32'hFFFF_FFFF, 32'h0000_0000);
        push_word(REQ_COMMAND, 32'd200, 3'd3, $urandom, $urandom);
        push_check(32'd300);
        push_check(32'd301);
        push_word(REQ_COMMAND, 32'd610, 3'd6, $urandom, $urandom);
        push_word(REQ_COMMAND, 32'd611, 3'd6, $urandom, $urandom);
        push_word(REQ_COMMAND, 32'd611, 3'd7, 32'h8000_0000, 32'h7FFF_FFFF);
        push_check(32'd712);
        push_check(32'd713);
        push_check(32'd714);
        push_check(32'd715);
        push_check(32'd716);
        // Timestamps that wrap through zero.
        push_word(REQ_COMMAND, 32'hFFFF_FFF0, 3'd0, $urandom, $urandom);
        push_word(REQ_COMMAND, 32'h0000_0010, 3'd5, $urandom, $urandom);
        push_check(32'h0000_0075);
        push_check(32'h0000_0076);

        // Repeat count lowered below the zeros already sent.
        wait_idle();
        write_reg(CFG_ZERO_REPS, 16'hA501);
        write_reg(CFG_UNUSED, 16'($urandom));
        push_check(32'h0000_0077);
        push_check(32'h0000_0078);

        // Zero hold-off, zero stop delay and a repeat count of zero.
        wait_idle();
        write_reg(CFG_HOLD_OFF, 16'd0);
        write_reg(CFG_STOP_DELAY, 16'd0);
        write_reg(CFG_ZERO_REPS, 16'h5A00);
        push_word(REQ_COMMAND, 32'd1000, 3'd7, $urandom, $urandom);
        push_word(REQ_COMMAND, 32'd1000, 3'd0, $urandom, $urandom);
        push_word(REQ_COMMAND, 32'd1001, 3'd0, $urandom, $urandom);
        push_check(32'd1001);
        push_check(32'd1002);
        push_check(32'd1003);
        stamp_ms = 32'd1003;

        // Reset values again, with a long result-side hold to back the block up.
        run_setting(16'd500, 16'd100, 8'd5, 0, 0, 75);
        @(negedge aclk);
        sink_hold_start = 1'b1;
        @(negedge aclk);
        sink_hold_start = 1'b0;

        // Minimum limits, sender mostly idle, with a full pause halfway.
        run_setting(16'd0, 16'd0, 8'd1, 70, 0, 40);
        wait_idle();
        run_words(35, 1, 3);

        // Maximum limits, receiver mostly stalling.
        run_setting(16'd65535, 16'd65535, 8'd255, 0, 70, 75);

        // Small limits just before the timestamp wraps, both sides idling.
        stamp_ms = 32'hFFFF_FF00;
        run_setting(16'd20, 16'd10, 8'd3, 17, 17, 75);

        // Repeat count of zero with random traffic.
        run_setting(16'd7, 16'd3, 8'd0, 0, 0, 75);

        // A random setting.
        run_setting(16'($urandom_range(0, 300)), 16'($urandom_range(0, 200)),
                    8'($urandom_range(1, 8)), 70, 0, 75);

        wait_idle();
        repeat (6) @(negedge aclk);
        if (mismatches == 0 && result_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
